/* sv/j2kls_pkg.sv */
// ----------------------------------------------------------------------------
// j2kls_pkg
// Shared types and constants for the codestream length scanner.
// ----------------------------------------------------------------------------
package j2kls_pkg;

  localparam int unsigned MAX_MARKERS = 65536;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned POS_W       = 34;
  localparam int unsigned LEN_W       = 32;

  localparam logic [31:0] MAX_LENGTH_RST = 32'd268435456;

  localparam logic [15:0] MRK_EOC = 16'hFFD9;
  localparam logic [15:0] MRK_SOT = 16'hFF90;
  localparam logic [15:0] MRK_SOC = 16'hFF4F;
  localparam logic [15:0] MRK_SOP = 16'hFF91;
  localparam logic [15:0] MRK_EPH = 16'hFF92;
  localparam logic [15:0] MRK_SEG_LO_A = 16'hFF51;
  localparam logic [15:0] MRK_SEG_HI_A = 16'hFF53;
  localparam logic [15:0] MRK_SEG_LO_B = 16'hFF5C;
  localparam logic [15:0] MRK_SEG_HI_B = 16'hFF63;

  localparam logic [31:0] PSOT_MIN    = 32'd14;
  localparam logic [15:0] SEG_LEN_MIN = 16'd2;

  localparam logic [3:0] OFS_FIELD   = 4'd2;
  localparam logic [3:0] OFS_PSOT_LO = 4'd6;
  localparam logic [3:0] OFS_PSOT_HI = 4'd9;
  localparam logic [3:0] OFS_LEN_LO  = 4'd2;
  localparam logic [3:0] OFS_LEN_HI  = 4'd3;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_EARLY = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SEEK = 5'b00010,
    PH_CODE = 5'b00100,
    PH_SOT  = 5'b01000,
    PH_SEG  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              hit;
    status_t           status;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

/* sv/j2kls_scan.sv */
// ----------------------------------------------------------------------------
// j2kls_scan
// Marker walk state and per-byte next-state / verdict logic.
// ----------------------------------------------------------------------------
module j2kls_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             data_byte,
  input  logic                   start_req,
  input  logic                   last,
  input  logic [31:0]            max_length,
  output j2kls_pkg::result_t     res
);

  j2kls_pkg::phase_t                  phase, phase_next;
  logic [j2kls_pkg::POS_W-1:0]        byte_position, byte_position_next;
  logic [j2kls_pkg::POS_W-1:0]        next_marker_position, next_marker_position_next;
  logic [7:0]                         code_hi, code_hi_next;
  logic [23:0]                        field_value, field_value_next;
  logic [3:0]                         offset, offset_next;
  logic [j2kls_pkg::CNT_W-1:0]        marker_count, marker_count_next;

  logic [15:0]                        code;
  logic [31:0]                        psot;
  logic [15:0]                        seg_len;
  logic                               bm_go;
  logic [j2kls_pkg::POS_W-1:0]        bm_pos;
  logic [j2kls_pkg::CNT_W-1:0]        cnt_base;
  logic                               seg_marker;

  assign code    = {code_hi, data_byte};
  assign psot    = {field_value, data_byte};
  assign seg_len = {field_value[7:0], data_byte};
  assign seg_marker = (code >= j2kls_pkg::MRK_SEG_LO_A && code <= j2kls_pkg::MRK_SEG_HI_A) ||
                      (code >= j2kls_pkg::MRK_SEG_LO_B && code <= j2kls_pkg::MRK_SEG_HI_B);

  always_comb begin
    phase_next                = phase;
    byte_position_next        = byte_position;
    next_marker_position_next = next_marker_position;
    code_hi_next              = code_hi;
    field_value_next          = field_value;
    offset_next               = offset;
    marker_count_next         = marker_count;
    cnt_base                  = marker_count;
    bm_go                     = 1'b0;
    bm_pos                    = '0;
    res.hit                   = 1'b0;
    res.status                = j2kls_pkg::STAT_OK;
    res.length                = '0;

    if (start_req) begin
      byte_position_next = j2kls_pkg::POS_W'(1);
      code_hi_next       = '0;
      field_value_next   = '0;
      cnt_base           = '0;
      bm_go              = 1'b1;
      bm_pos             = j2kls_pkg::POS_W'(2);
    end else begin
      unique case (phase)
        j2kls_pkg::PH_IDLE: begin
        end
        j2kls_pkg::PH_SEEK: begin
          byte_position_next = byte_position + 1'b1;
          if (byte_position == next_marker_position) begin
            code_hi_next = data_byte;
            phase_next   = j2kls_pkg::PH_CODE;
          end
        end
        j2kls_pkg::PH_CODE: begin
          byte_position_next = byte_position + 1'b1;
          field_value_next   = '0;
          offset_next        = j2kls_pkg::OFS_FIELD;
          if (code == j2kls_pkg::MRK_EOC) begin
            res.hit    = 1'b1;
            res.status = j2kls_pkg::STAT_OK;
            res.length = j2kls_pkg::LEN_W'(next_marker_position + j2kls_pkg::POS_W'(2));
            phase_next = j2kls_pkg::PH_IDLE;
          end else if (code == j2kls_pkg::MRK_SOT) begin
            phase_next = j2kls_pkg::PH_SOT;
          end else if (seg_marker) begin
            phase_next = j2kls_pkg::PH_SEG;
          end else if (code == j2kls_pkg::MRK_SOC || code == j2kls_pkg::MRK_SOP ||
                       code == j2kls_pkg::MRK_EPH) begin
            bm_go  = 1'b1;
            bm_pos = next_marker_position + j2kls_pkg::POS_W'(2);
          end else begin
            res.hit    = 1'b1;
            res.status = j2kls_pkg::STAT_BAD;
            phase_next = j2kls_pkg::PH_IDLE;
          end
        end
        j2kls_pkg::PH_SOT: begin
          byte_position_next = byte_position + 1'b1;
          offset_next        = offset + 1'b1;
          if (offset >= j2kls_pkg::OFS_PSOT_LO) begin
            field_value_next = {field_value[15:0], data_byte};
            if (offset == j2kls_pkg::OFS_PSOT_HI) begin
              if (psot < j2kls_pkg::PSOT_MIN) begin
                res.hit    = 1'b1;
                res.status = j2kls_pkg::STAT_BAD;
                phase_next = j2kls_pkg::PH_IDLE;
              end else begin
                bm_go  = 1'b1;
                bm_pos = next_marker_position + {2'b00, psot};
              end
            end
          end
        end
        j2kls_pkg::PH_SEG: begin
          byte_position_next = byte_position + 1'b1;
          offset_next        = offset + 1'b1;
          if (offset == j2kls_pkg::OFS_LEN_LO) begin
            field_value_next = {16'h0000, data_byte};
          end else if (offset == j2kls_pkg::OFS_LEN_HI) begin
            field_value_next = {8'h00, seg_len};
            if (seg_len < j2kls_pkg::SEG_LEN_MIN) begin
              res.hit    = 1'b1;
              res.status = j2kls_pkg::STAT_BAD;
              phase_next = j2kls_pkg::PH_IDLE;
            end else begin
              bm_go  = 1'b1;
              bm_pos = next_marker_position + j2kls_pkg::POS_W'(2) + {18'h0, seg_len};
            end
          end
        end
        default: begin
          phase_next = j2kls_pkg::PH_IDLE;
        end
      endcase
    end

    // open the next marker: count limit, then length limit
    if (bm_go) begin
      next_marker_position_next = bm_pos;
      if (cnt_base >= j2kls_pkg::CNT_W'(j2kls_pkg::MAX_MARKERS)) begin
        res.hit    = 1'b1;
        res.status = j2kls_pkg::STAT_BAD;
        phase_next = j2kls_pkg::PH_IDLE;
      end else begin
        marker_count_next = cnt_base + 1'b1;
        if (bm_pos + j2kls_pkg::POS_W'(2) > {2'b00, max_length}) begin
          res.hit    = 1'b1;
          res.status = j2kls_pkg::STAT_BAD;
          phase_next = j2kls_pkg::PH_IDLE;
        end else begin
          phase_next = j2kls_pkg::PH_SEEK;
        end
      end
    end else if (start_req) begin
      marker_count_next = cnt_base;
    end

    if (!res.hit && last && phase_next != j2kls_pkg::PH_IDLE) begin
      res.hit    = 1'b1;
      res.status = j2kls_pkg::STAT_EARLY;
      res.length = '0;
      phase_next = j2kls_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= j2kls_pkg::PH_IDLE;
      byte_position        <= '0;
      next_marker_position <= '0;
      code_hi              <= '0;
      field_value          <= '0;
      offset               <= '0;
      marker_count         <= '0;
    end else if (fire) begin
      phase                <= phase_next;
      byte_position        <= byte_position_next;
      next_marker_position <= next_marker_position_next;
      code_hi              <= code_hi_next;
      field_value          <= field_value_next;
      offset               <= offset_next;
      marker_count         <= marker_count_next;
    end
  end

endmodule

/* sv/jpeg2000_codestream_length_scan.sv */
// ----------------------------------------------------------------------------
// jpeg2000_codestream_length_scan
// Walks the marker structure of a candidate codestream one byte per beat and
// reports at most one verdict (found end, invalid, ended early) per scan.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  input   | in_valid in_ready data_byte start_req last   | in
//  result  | out_valid out_ready status length            | out
//  config  | cfg_valid cfg_ready cfg_data (max_length)    | in
//
//  one byte per cycle while no result waits on a low out_ready; a verdict
//  enters the result register when its byte leaves the input register
//  input register -> marker walk logic -> result register
//  the input stage holds while a result waits and out_ready is low
//  cfg_ready is always high; rst clears the scan to idle, max_length 2^28
// ----------------------------------------------------------------------------
module jpeg2000_codestream_length_scan (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_req,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic               in_full;
  logic [7:0]         ib_data;
  logic               ib_start;
  logic               ib_last;
  logic               advance;
  logic [31:0]        max_length;
  j2kls_pkg::result_t res;
  j2kls_pkg::status_t out_status;
  logic [31:0]        out_length;

  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= j2kls_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_data  <= data_byte;
      ib_start <= start_req;
      ib_last  <= last;
    end
  end

  j2kls_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .data_byte  (ib_data),
    .start_req  (ib_start),
    .last       (ib_last),
    .max_length (max_length),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      out_status <= res.status;
      out_length <= res.length;
    end
  end

  assign status = out_status;
  assign length = out_length;

endmodule

/* sv/j2kls_checker.sv */
// ----------------------------------------------------------------------------
// j2kls_checker
// Port-level checks on the result channel of the length scanner.
// ----------------------------------------------------------------------------
module j2kls_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] length
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(length))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == j2kls_pkg::STAT_OK || status == j2kls_pkg::STAT_BAD ||
                   status == j2kls_pkg::STAT_EARLY))
    else $error("undefined status code");

  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != j2kls_pkg::STAT_OK |-> length == 32'd0)
    else $error("nonzero length on failed scan");

  // end marker sits at position 2 or later
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == j2kls_pkg::STAT_OK |-> length >= 32'd4)
    else $error("found length shorter than start plus end marker");

  // no result beat is valid just after reset: a byte must pass the input register first
  a_first_result: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind jpeg2000_codestream_length_scan j2kls_checker u_j2kls_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .length    (length)
);

/* sim/jpeg2000_codestream_length_scan_tb.sv */
// ----------------------------------------------------------------------------
// jpeg2000_codestream_length_scan_tb
// Self-checking bench for the codestream length scanner. A short table of
// directed codestreams comes first, then random marker streams, mostly well
// formed with random content and some corrupted, cut or ended early. Every
// accepted byte goes through an in-bench model of the marker walk, and each
// verdict beat is compared with the oldest predicted verdict. The run uses
// three idle mixes and several max_length settings, among them the lowest
// and the highest.
// ----------------------------------------------------------------------------
module jpeg2000_codestream_length_scan_tb;
  import j2kls_pkg::*;

  typedef struct packed {
    logic [7:0] dat;
    logic       first;
    logic       fin;
  } beat_t;

  typedef struct packed {
    logic [7:0]  dat;
    logic        first;
    logic        fin;
    logic        cfg;
    logic [31:0] cfg_val;
    logic        typed;
    logic        hit;
    status_t     st;
    logic [31:0] len;
  } dir_row_t;

  typedef enum int {
    BRK_NONE,
    BRK_CORRUPT,
    BRK_LAST,
    BRK_CUT,
    BRK_FIELD,
    BRK_CODE
  } scan_fault_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        start_req = 1'b0;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = 32'd0;

  // scan model state
  phase_t           sc_phase = PH_IDLE;
  logic [POS_W-1:0] sc_pos   = '0;
  logic [POS_W-1:0] sc_mark  = '0;
  logic [15:0]      sc_code  = '0;
  logic [31:0]      sc_field = '0;
  logic [CNT_W-1:0] sc_count = '0;
  logic [31:0]      lim_length = MAX_LENGTH_RST;

  result_t verdict_q[$];
  int      errors       = 0;
  int      scan_items   = 0;
  int      verdicts_due = 0;
  int      results_seen = 0;
  int      cfg_writes   = 0;
  int      tx_idle_pct  = 7;
  int      rx_idle_pct  = 87;
  bit      hold_go      = 1'b0;
  logic    hold_rx      = 1'b0;

  dir_row_t dir_rows [0:26] = '{
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h4F, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'hD9, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b1, STAT_OK,    32'd4},
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h4F, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h4F, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h5C, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 32'd0,         1'b1, 1'b1, STAT_BAD,   32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0,         1'b1, 1'b0, STAT_OK,    32'd0},
    '{8'h4F, 1'b0, 1'b1, 1'b0, 32'd0,         1'b1, 1'b1, STAT_EARLY, 32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 32'd3,         1'b1, 1'b1, STAT_BAD,   32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'h4F, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'h52, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'h02, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'h91, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'hD9, 1'b0, 1'b0, 1'b0, 32'd0,         1'b0, 1'b0, STAT_OK,    32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 32'd2,         1'b1, 1'b1, STAT_BAD,   32'd0}
  };

  jpeg2000_codestream_length_scan DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .start_req (start_req),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .length    (length),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("%0t: timeout, %0d verdicts still pending", $time, verdict_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin : verdict_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict beat with none expected, got status %0d length %0d",
                 $time, status, length);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        results_seen++;
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, status);
          errors++;
        end
        if (length !== want.length) begin
          $display("%0t: length mismatch, expected %0d, got %0d",
                   $time, want.length, length);
          errors++;
        end
      end
    end
    out_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void queue_verdict(input result_t r);
    verdict_q.insert(verdict_q.size(), r);
    verdicts_due++;
  endfunction

  function automatic void add_beat(ref beat_t q[$], input logic [7:0] d, input logic f,
                                   input logic e);
    beat_t b;
    b.dat   = d;
    b.first = f;
    b.fin   = e;
    q.insert(q.size(), b);
  endfunction

  function automatic result_t close_scan(input status_t s, input logic [31:0] l);
    result_t r;
    r.hit    = 1'b1;
    r.status = s;
    r.length = l;
    sc_phase = PH_IDLE;
    return r;
  endfunction

  // returns 1 when the marker at p ends the scan as invalid
  function automatic bit open_marker(input logic [POS_W-1:0] p);
    sc_mark = p;
    if (sc_count >= MAX_MARKERS) return 1'b1;
    sc_count = sc_count + 1'b1;
    if (p + 2 > {2'b00, lim_length}) return 1'b1;
    sc_phase = PH_SEEK;
    return 1'b0;
  endfunction

  function automatic result_t step_scan(input logic [7:0] d, input logic f,
                                        input logic e);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] sum;
    result_t none;
    none = '0;
    if (f) begin
      sc_pos   = POS_W'(1);
      sc_count = '0;
      sc_code  = '0;
      sc_field = '0;
      if (open_marker(POS_W'(2))) return close_scan(STAT_BAD, '0);
    end else begin
      if (sc_phase == PH_IDLE) return none;
      pos    = sc_pos;
      rel    = pos - sc_mark;
      sc_pos = pos + 1'b1;
      case (sc_phase)
        PH_SEEK: if (pos == sc_mark) begin
          sc_code  = {8'h00, d};
          sc_phase = PH_CODE;
        end
        PH_CODE: begin
          sc_code  = {sc_code[7:0], d};
          sc_field = '0;
          if (sc_code == MRK_EOC) begin
            sum = sc_mark + 2;
            return close_scan(STAT_OK, sum[31:0]);
          end else if (sc_code == MRK_SOT) begin
            sc_phase = PH_SOT;
          end else if ((sc_code >= MRK_SEG_LO_A && sc_code <= MRK_SEG_HI_A) ||
                       (sc_code >= MRK_SEG_LO_B && sc_code <= MRK_SEG_HI_B)) begin
            sc_phase = PH_SEG;
          end else if (sc_code == MRK_SOC || sc_code == MRK_SOP || sc_code == MRK_EPH) begin
            if (open_marker(sc_mark + 2)) return close_scan(STAT_BAD, '0);
          end else begin
            return close_scan(STAT_BAD, '0);
          end
        end
        PH_SOT: if (rel >= OFS_PSOT_LO && rel <= OFS_PSOT_HI) begin
          sc_field = {sc_field[23:0], d};
          if (rel == OFS_PSOT_HI) begin
            if (sc_field < PSOT_MIN) return close_scan(STAT_BAD, '0);
            if (open_marker(sc_mark + {2'b00, sc_field})) return close_scan(STAT_BAD, '0);
          end
        end
        PH_SEG: if (rel >= OFS_LEN_LO && rel <= OFS_LEN_HI) begin
          sc_field = {16'h0000, sc_field[7:0], d};
          if (rel == OFS_LEN_HI) begin
            if (sc_field[15:0] < SEG_LEN_MIN) return close_scan(STAT_BAD, '0);
            if (open_marker(sc_mark + 2 + {2'b00, sc_field}))
              return close_scan(STAT_BAD, '0);
          end
        end
        default: begin
          sc_phase = PH_IDLE;
          return none;
        end
      endcase
    end
    if (e && sc_phase != PH_IDLE) return close_scan(STAT_EARLY, '0);
    return none;
  endfunction

  task automatic offer_byte(input logic [7:0] d, input logic f, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    start_req <= f;
    last      <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] d, input logic f, input logic e);
    result_t r;
    offer_byte(d, f, e);
    scan_items++;
    r = step_scan(d, f, e);
    if (r.hit) queue_verdict(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [31:0] v);
    if (sc_phase != PH_IDLE) feed(8'($urandom), 1'b0, 1'b1);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    lim_length = v;
    cfg_writes++;
  endtask

  // one codestream from SOC to EOC, sometimes with a fault
  task automatic play_scan();
    beat_t       cs[$];
    beat_t       tmp;
    scan_fault_t brk;
    int          n, k, j, fill, at;
    bit          broke;
    logic [15:0] code;
    logic [15:0] seglen;
    logic [31:0] psot;
    broke = 1'b0;
    brk = ($urandom_range(3) == 0) ? scan_fault_t'($urandom_range(1, 5)) : BRK_NONE;
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) feed(8'($urandom), 1'b0, 1'($urandom));
    add_beat(cs, 8'hFF, 1'b1, 1'b0);
    add_beat(cs, 8'h4F, 1'b0, 1'b0);
    n = $urandom_range(0, 5);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(2))
        0: begin
          case ($urandom_range(2))
            0:       code = MRK_SOC;
            1:       code = MRK_SOP;
            default: code = MRK_EPH;
          endcase
          add_beat(cs, code[15:8], 1'b0, 1'b0);
          add_beat(cs, code[7:0], 1'b0, 1'b0);
        end
        1: begin
          code = $urandom_range(1) ? 16'(MRK_SEG_LO_A + $urandom_range(2))
                                   : 16'(MRK_SEG_LO_B + $urandom_range(7));
          seglen = 16'($urandom_range(2, 9));
          if (brk == BRK_FIELD && !broke) begin
            broke  = 1'b1;
            seglen = $urandom_range(1) ? 16'($urandom_range(1)) : {8'hFF, 8'($urandom)};
          end
          add_beat(cs, code[15:8], 1'b0, 1'b0);
          add_beat(cs, code[7:0], 1'b0, 1'b0);
          add_beat(cs, seglen[15:8], 1'b0, 1'b0);
          add_beat(cs, seglen[7:0], 1'b0, 1'b0);
          fill = (seglen >= 2 && seglen <= 9) ? seglen - 2 : 0;
          repeat (fill) add_beat(cs, 8'($urandom), 1'b0, 1'b0);
        end
        default: begin
          psot = $urandom_range(14, 24);
          if (brk == BRK_FIELD && !broke) begin
            broke = 1'b1;
            psot  = $urandom_range(1) ? 32'($urandom_range(13)) : {28'hFFFFFFF, 4'($urandom)};
          end
          add_beat(cs, MRK_SOT[15:8], 1'b0, 1'b0);
          add_beat(cs, MRK_SOT[7:0], 1'b0, 1'b0);
          repeat (4) add_beat(cs, 8'($urandom), 1'b0, 1'b0);
          for (j = 3; j >= 0; j--) add_beat(cs, psot[8*j +: 8], 1'b0, 1'b0);
          fill = (psot >= 14 && psot <= 24) ? psot - 10 : 0;
          repeat (fill) add_beat(cs, 8'($urandom), 1'b0, 1'b0);
        end
      endcase
    end
    add_beat(cs, MRK_EOC[15:8], 1'b0, 1'b0);
    add_beat(cs, MRK_EOC[7:0], 1'b0, 1'b0);
    case (brk)
      BRK_CORRUPT: begin
        at = $urandom_range(2, cs.size() - 1);
        tmp = cs[at];
        tmp.dat = 8'($urandom);
        cs[at] = tmp;
      end
      BRK_LAST: begin
        at = $urandom_range(0, cs.size() - 1);
        tmp = cs[at];
        tmp.fin = 1'b1;
        cs[at] = tmp;
        while (cs.size() > at + 1) cs.delete(cs.size() - 1);
      end
      BRK_CUT: begin
        at = $urandom_range(1, cs.size() - 1);
        while (cs.size() > at) cs.delete(cs.size() - 1);
      end
      BRK_CODE: begin
        tmp = cs[cs.size() - 1];
        tmp.dat = 8'($urandom);
        cs[cs.size() - 1] = tmp;
      end
      BRK_NONE: if ($urandom_range(7) == 0) begin
        tmp = cs[cs.size() - 1];
        tmp.fin = 1'b1;
        cs[cs.size() - 1] = tmp;
      end
      default: ;
    endcase
    for (k = 0; k < cs.size(); k++) begin
      tmp = cs[k];
      feed(tmp.dat, tmp.first, tmp.fin);
    end
  endtask

  task automatic random_scans(input int n_items);
    int goal;
    goal = scan_items + n_items;
    while (scan_items < goal) play_scan();
  endtask

  initial begin : stimulus
    dir_row_t row;
    result_t  got;
    int       i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset max_length, then extremes
    for (i = 0; i < $size(dir_rows); i++) begin
      row = dir_rows[i];
      if (row.cfg) set_max_length(row.cfg_val);
      offer_byte(row.dat, row.first, row.fin);
      scan_items++;
      got = step_scan(row.dat, row.first, row.fin);
      if (row.typed) begin
        got.hit    = row.hit;
        got.status = row.st;
        got.length = row.len;
      end
      if (got.hit) queue_verdict(got);
    end

    // slow receiver
    set_max_length(32'hFFFF_FFFF);
    random_scans(160);
    drain();
    random_scans(160);

    // slow sender, short max_length
    tx_idle_pct = 87;
    rx_idle_pct = 7;
    set_max_length($urandom_range(24, 120));
    random_scans(160);
    set_max_length($urandom_range(24, 120));
    random_scans(160);

    // no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_max_length(32'd2);
    repeat (4) play_scan();
    set_max_length(MAX_LENGTH_RST);
    hold_go = 1'b1;
    random_scans(100);
    while (verdicts_due < 60) play_scan();

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d input beats and %0d verdicts (%0d checked) over %0d max_length writes,",
             scan_items, verdicts_due, results_seen, cfg_writes);
    $display("including a 400-cycle receiver hold-off, full drains and three idle mixes");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
